FILE: hw/rtl/wpc_pkg.sv
// Package for the wildcard pattern compare core: types, character codes and helpers.
// Used by wpc_cell, wpc_prefix and wildcard_pattern_compare_core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wpc_pkg;

  // Pattern store depth, one cell per stored byte
  localparam int unsigned PATTERN_DEPTH = 64;
  // Active-position vector spans every body position plus the one past the end
  localparam int unsigned NFA_W = PATTERN_DEPTH + 1;

  // Input transaction codes
  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_SUBJECT = 2'd2,
    FUNC_END     = 2'd3
  } func_e;

  // Compare modes chosen by the pattern prefix
  typedef enum logic [2:0] {
    MODE_EQ = 3'd0,
    MODE_NE = 3'd1,
    MODE_LT = 3'd2,
    MODE_GT = 3'd3,
    MODE_LE = 3'd4,
    MODE_GE = 3'd5,
    MODE_RX = 3'd6
  } mode_e;

  // Lexicographic ordering so far
  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_LESS    = 2'd1,
    ORD_GREATER = 2'd2
  } order_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_REGEX    = 2'd2
  } status_e;

  // Character codes
  localparam logic [7:0] CHR_STAR      = 8'h2A;
  localparam logic [7:0] CHR_QUESTION  = 8'h3F;
  localparam logic [7:0] CHR_CARET     = 8'h5E;
  localparam logic [7:0] CHR_PERCENT   = 8'h25;
  localparam logic [7:0] CHR_GREATER   = 8'h3E;
  localparam logic [7:0] CHR_LESS      = 8'h3C;
  localparam logic [7:0] CHR_EQUALS    = 8'h3D;
  localparam logic [7:0] CHR_BANG      = 8'h21;
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z   = 8'h7A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  typedef struct packed {
    func_e      func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic    match;
    status_e status;
  } out_item_t;

  // Decoded pattern prefix
  typedef struct packed {
    mode_e      mode;
    logic       fold_case;
    logic [1:0] body_start;
  } prefix_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic       clear;
    logic       append;
    logic       step;
    logic       fresh;
    logic       fold_case;
    logic [7:0] wr_byte;
    logic [7:0] subj_char;
  } cell_ctrl_t;

  // Per-cell results gathered by the top level and the next cell
  typedef struct packed {
    logic valid;
    logic star;
    logic act;
    logic keep;
    logic adv;
    logic tok;
    logic tokv;
    logic lt;
    logic gt;
  } cell_out_t;

  // ASCII upper-case folding when enabled
  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c >= CHR_LOWER_A) && (c <= CHR_LOWER_Z)) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wpc_cell.sv
// One pattern cell: a stored byte, its fill bit, one glob position bit and one
// ordering token bit. Depends on wpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpc_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wpc_pkg::cell_ctrl_t ctrl_i,
  input  wire                 prev_valid_i,
  input  wire                 prev_adv_i,
  input  wire                 prev_tok_i,
  input  wire                 start_i,
  input  wire                 cl_i,
  output logic [7:0]          byte_o,
  output wpc_pkg::cell_out_t  out_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       act_q, act_d;
  logic       tok_q, tok_d;
  logic [7:0] pc;
  logic       act_eff, tok_eff, star, hit, wr_en;

  // Local view of the stored byte and the live position bits
  always_comb begin
    pc      = wpc_pkg::fold_char(byte_q, ctrl_i.fold_case);
    star    = valid_q && (byte_q == wpc_pkg::CHR_STAR);
    act_eff = ctrl_i.fresh ? start_i : act_q;
    tok_eff = ctrl_i.fresh ? start_i : tok_q;
    hit     = (pc == wpc_pkg::CHR_QUESTION) || (pc == ctrl_i.subj_char);
    wr_en   = ctrl_i.append && !valid_q && prev_valid_i;
  end

  // Results to the top level and the next cell
  always_comb begin
    out_o.valid = valid_q;
    out_o.star  = star;
    out_o.act   = act_eff;
    out_o.keep  = cl_i && star;
    out_o.adv   = cl_i && valid_q && !star && hit;
    out_o.tok   = tok_eff;
    out_o.tokv  = tok_eff && valid_q;
    out_o.lt    = tok_eff && valid_q && (ctrl_i.subj_char < pc);
    out_o.gt    = tok_eff && valid_q && (ctrl_i.subj_char > pc);
  end

  assign byte_o = byte_q;

  // Next state: clear or fill on the first free cell, shift positions on a subject byte
  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    act_d   = act_q;
    tok_d   = tok_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (wr_en) begin
      valid_d = 1'b1;
      byte_d  = ctrl_i.wr_byte;
    end
    if (ctrl_i.step) begin
      act_d = out_o.keep || prev_adv_i;
      tok_d = prev_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      act_q   <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      act_q   <= act_d;
      tok_q   <= tok_d;
    end
  end

  // Pattern byte, meaningful only while valid
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wpc_prefix.sv
// Operator prefix decoder: compare mode, case folding and body start from the
// first three pattern bytes. Depends on wpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpc_prefix (
  input  wire  [7:0]       b0_i,
  input  wire  [7:0]       b1_i,
  input  wire  [7:0]       b2_i,
  input  wire  [2:0]       v_i,
  output wpc_pkg::prefix_t prefix_o
);

  wpc_pkg::mode_e mode;
  logic [1:0]     phase;
  logic           caret;
  logic           is_eq1, is_gt1, is_lt1;

  // Second-byte tests, an absent byte matches nothing
  always_comb begin
    is_eq1 = v_i[1] && (b1_i == wpc_pkg::CHR_EQUALS);
    is_gt1 = v_i[1] && (b1_i == wpc_pkg::CHR_GREATER);
    is_lt1 = v_i[1] && (b1_i == wpc_pkg::CHR_LESS);
  end

  // Operator table
  always_comb begin
    mode  = wpc_pkg::MODE_EQ;
    phase = 2'd0;
    if (v_i[0]) begin
      case (b0_i)
        wpc_pkg::CHR_PERCENT: begin
          mode  = wpc_pkg::MODE_RX;
          phase = 2'd1;
        end
        wpc_pkg::CHR_GREATER: begin
          mode  = is_eq1 ? wpc_pkg::MODE_GE : wpc_pkg::MODE_GT;
          phase = is_eq1 ? 2'd2 : 2'd1;
        end
        wpc_pkg::CHR_LESS: begin
          if (is_eq1) begin
            mode  = wpc_pkg::MODE_LE;
            phase = 2'd2;
          end else if (is_gt1) begin
            mode  = wpc_pkg::MODE_NE;
            phase = 2'd2;
          end else begin
            mode  = wpc_pkg::MODE_LT;
            phase = 2'd1;
          end
        end
        wpc_pkg::CHR_EQUALS: begin
          if (is_eq1) begin
            mode  = wpc_pkg::MODE_EQ;
            phase = 2'd2;
          end else if (is_gt1) begin
            mode  = wpc_pkg::MODE_LE;
            phase = 2'd2;
          end else if (is_lt1) begin
            mode  = wpc_pkg::MODE_GE;
            phase = 2'd2;
          end else begin
            mode  = wpc_pkg::MODE_EQ;
            phase = 2'd1;
          end
        end
        wpc_pkg::CHR_BANG: begin
          mode  = wpc_pkg::MODE_NE;
          phase = is_eq1 ? 2'd2 : 2'd1;
        end
        wpc_pkg::CHR_BACKSLASH: begin
          mode  = wpc_pkg::MODE_EQ;
          phase = 2'd1;
        end
        default: begin
          mode  = wpc_pkg::MODE_EQ;
          phase = 2'd0;
        end
      endcase
    end
  end

  // Caret straight after the operator turns on folding, except in regex mode
  always_comb begin
    case (phase)
      2'd0:    caret = v_i[0] && (b0_i == wpc_pkg::CHR_CARET);
      2'd1:    caret = v_i[1] && (b1_i == wpc_pkg::CHR_CARET);
      2'd2:    caret = v_i[2] && (b2_i == wpc_pkg::CHR_CARET);
      default: caret = 1'b0;
    endcase
    if (mode == wpc_pkg::MODE_RX) begin
      caret = 1'b0;
    end
    prefix_o.mode       = mode;
    prefix_o.fold_case  = caret;
    prefix_o.body_start = caret ? (phase + 2'd1) : phase;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wildcard_pattern_compare_core.sv
// Top level of the wildcard pattern compare core: cell chain, star closure,
// ordering state and output register. Depends on wpc_pkg, wpc_cell, wpc_prefix.
//
//   port group   dir  payload             handshake
//   in           in   wpc_pkg::in_item_t  in_valid_i / in_stall_o
//   out          out  wpc_pkg::out_item_t out_valid_o / out_stall_i
//
// One transaction per cycle on the input while it is not stalled, every function
// code alike; the result of an end-of-subject item sits in the output register in the next cycle.
// The critical path is the star closure: one add across the active-position
// vector, then the per-cell next-position logic.
// The input stalls only while a result is held and the output is stalled.
// Reset is asynchronous and leaves an empty pattern in equal mode.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_pattern_compare_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wpc_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output wpc_pkg::out_item_t  out_data_o
);

  localparam int unsigned Depth = wpc_pkg::PATTERN_DEPTH;
  localparam int unsigned NfaW  = wpc_pkg::NFA_W;

  logic                 in_acc, is_clear, is_append, is_step, is_end;
  logic                 fresh_q, fresh_d;
  logic                 overflow_q, overflow_d;
  wpc_pkg::order_e      order_q, order_d, ord_eff, ord_fin;
  logic                 act_tail_q, act_tail_d, tok_tail_q, tok_tail_d;
  logic                 act_tail_eff, tok_tail_eff;
  logic                 out_valid_q, out_valid_d;
  wpc_pkg::out_item_t   out_data_q, out_data_d;
  wpc_pkg::prefix_t     pre;
  wpc_pkg::cell_ctrl_t  ctrl;
  wpc_pkg::cell_out_t   co [Depth];
  logic [7:0]           cbyte [Depth];
  logic [NfaW-1:0]      valid_v, star_v, act_v, carry_v, cl_v, end_oh, start_oh;
  logic [NfaW:0]        csum, valid_ext;
  logic [Depth-1:0]     tokv_v, lt_v, gt_v;
  logic                 glob, tokv_any, lt_any, gt_any, res_match;
  wpc_pkg::status_e     res_status;

  // Input decode
  always_comb begin
    in_acc    = in_valid_i && !in_stall_o;
    is_clear  = in_acc && (in_data_i.func == wpc_pkg::FUNC_CLEAR);
    is_append = in_acc && (in_data_i.func == wpc_pkg::FUNC_APPEND);
    is_step   = in_acc && (in_data_i.func == wpc_pkg::FUNC_SUBJECT);
    is_end    = in_acc && (in_data_i.func == wpc_pkg::FUNC_END);
  end

  assign in_stall_o = out_valid_q && out_stall_i;

  // Prefix from the first three cells
  wpc_prefix u_prefix (
    .b0_i     (cbyte[0]),
    .b1_i     (cbyte[1]),
    .b2_i     (cbyte[2]),
    .v_i      ({co[2].valid, co[1].valid, co[0].valid}),
    .prefix_o (pre)
  );

  // Broadcast to the cells
  always_comb begin
    ctrl.clear     = is_clear;
    ctrl.append    = is_append;
    ctrl.step      = is_step;
    ctrl.fresh     = fresh_q;
    ctrl.fold_case = pre.fold_case;
    ctrl.wr_byte   = in_data_i.data_byte;
    ctrl.subj_char = wpc_pkg::fold_char(in_data_i.data_byte, pre.fold_case);
  end

  assign start_oh = NfaW'(1) << pre.body_start;

  // Cell chain
  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic prev_valid, prev_adv, prev_tok;
    if (k == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_adv   = 1'b0;
      assign prev_tok   = 1'b0;
    end else begin : g_link
      assign prev_valid = co[k-1].valid;
      assign prev_adv   = co[k-1].adv;
      assign prev_tok   = co[k-1].tok;
    end

    wpc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid),
      .prev_adv_i   (prev_adv),
      .prev_tok_i   (prev_tok),
      .start_i      (start_oh[k]),
      .cl_i         (cl_v[k]),
      .byte_o       (cbyte[k]),
      .out_o        (co[k])
    );
  end

  // Gather the cell flags, plus the position one past the last cell
  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      valid_v[k] = co[k].valid;
      star_v[k]  = co[k].star;
      act_v[k]   = co[k].act;
      tokv_v[k]  = co[k].tokv;
      lt_v[k]    = co[k].lt;
      gt_v[k]    = co[k].gt;
    end
    act_tail_eff   = fresh_q ? start_oh[Depth] : act_tail_q;
    tok_tail_eff   = fresh_q ? start_oh[Depth] : tok_tail_q;
    valid_v[Depth] = 1'b0;
    star_v[Depth]  = 1'b0;
    act_v[Depth]   = act_tail_eff;
  end

  // Star closure: runs of stars behave as a carry chain
  always_comb begin
    csum    = {1'b0, star_v} + {1'b0, act_v & star_v};
    carry_v = csum[NfaW-1:0] ^ star_v ^ (act_v & star_v);
    cl_v    = act_v | carry_v;
  end

  // Glob hit at the first empty cell, ordering flags from the token cell
  always_comb begin
    valid_ext = {valid_v, 1'b1};
    end_oh    = valid_ext[NfaW-1:0] & ~valid_v;
    glob      = |(cl_v & end_oh);
    tokv_any  = |tokv_v;
    lt_any    = |lt_v;
    gt_any    = |gt_v;
  end

  // Ordering state
  always_comb begin
    ord_eff = fresh_q ? wpc_pkg::ORD_EQUAL : order_q;
    order_d = order_q;
    if (is_step) begin
      order_d = ord_eff;
      if (ord_eff == wpc_pkg::ORD_EQUAL) begin
        if (lt_any) begin
          order_d = wpc_pkg::ORD_LESS;
        end else if (gt_any || !tokv_any) begin
          order_d = wpc_pkg::ORD_GREATER;
        end
      end
    end
    ord_fin = ((ord_eff == wpc_pkg::ORD_EQUAL) && tokv_any) ? wpc_pkg::ORD_LESS : ord_eff;
  end

  // Result of an end-of-subject transaction
  always_comb begin
    res_match  = 1'b0;
    res_status = wpc_pkg::STATUS_OK;
    if (overflow_q) begin
      res_status = wpc_pkg::STATUS_OVERFLOW;
    end else if (pre.mode == wpc_pkg::MODE_RX) begin
      res_status = wpc_pkg::STATUS_REGEX;
    end else begin
      case (pre.mode)
        wpc_pkg::MODE_EQ: res_match = glob;
        wpc_pkg::MODE_NE: res_match = !glob;
        wpc_pkg::MODE_LT: res_match = (ord_fin == wpc_pkg::ORD_LESS);
        wpc_pkg::MODE_GT: res_match = (ord_fin == wpc_pkg::ORD_GREATER);
        wpc_pkg::MODE_LE: res_match = (ord_fin != wpc_pkg::ORD_GREATER);
        default:          res_match = (ord_fin != wpc_pkg::ORD_LESS);
      endcase
    end
  end

  // Control next state
  always_comb begin
    fresh_d    = fresh_q;
    overflow_d = overflow_q;
    act_tail_d = act_tail_q;
    tok_tail_d = tok_tail_q;
    if (is_clear || is_append || is_end) begin
      fresh_d = 1'b1;
    end else if (is_step) begin
      fresh_d    = 1'b0;
      act_tail_d = co[Depth-1].adv;
      tok_tail_d = tok_tail_eff || co[Depth-1].tok;
    end
    if (is_clear) begin
      overflow_d = 1'b0;
    end else if (is_append && valid_v[Depth-1]) begin
      overflow_d = 1'b1;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (is_end) begin
      out_valid_d      = 1'b1;
      out_data_d.match  = res_match;
      out_data_d.status = res_status;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q     <= 1'b1;
      overflow_q  <= 1'b0;
      order_q     <= wpc_pkg::ORD_EQUAL;
      act_tail_q  <= 1'b0;
      tok_tail_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fresh_q     <= fresh_d;
      overflow_q  <= overflow_d;
      order_q     <= order_d;
      act_tail_q  <= act_tail_d;
      tok_tail_q  <= tok_tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: verif/wpc_match_checker.sv
// Checker for the wildcard pattern compare core: predicts each end-of-subject verdict
// from the accepted input transactions and compares it with the output channel.
// Depends on wpc_pkg for the payload types, mode codes and character codes.
`timescale 1ns / 1ps

module wpc_match_checker
  import wpc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_stall_i,
  input  in_item_t   in_data_i,
  input  wire        out_valid_i,
  input  wire        out_stall_i,
  input  out_item_t  out_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  // Shadow copy of the pattern and the matching state
  logic [7:0]       pat_mem [PATTERN_DEPTH];
  int unsigned      pat_len;
  mode_e            cmp_mode;
  bit               fold_en;
  int unsigned      body_idx;
  logic [NFA_W-1:0] live;
  order_e           ord_so_far;
  int unsigned      subj_pos;
  bit               ovf;

  out_item_t        verdicts [$];

  // Stored byte, or 256 past the end of the pattern
  function automatic int raw_byte(int unsigned i);
    if (i < pat_len) return int'(pat_mem[i]);
    return 256;
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    if (fold_en && c >= CHR_LOWER_A && c <= CHR_LOWER_Z) return c - CASE_OFFSET;
    return c;
  endfunction

  function automatic int unsigned body_length();
    return (pat_len > body_idx) ? pat_len - body_idx : 0;
  endfunction

  function automatic logic [7:0] body_byte(int unsigned j);
    int unsigned k;
    k = body_idx + j;
    if (k < pat_len) return upcase(pat_mem[k]);
    return 8'h00;
  endfunction

  // Mode, case folding and body start from the leading bytes
  function automatic void decode_prefix();
    int          b0;
    int          b1;
    mode_e       m;
    int unsigned ph;
    b0 = raw_byte(0);
    b1 = raw_byte(1);
    m  = MODE_EQ;
    ph = 0;
    if (b0 == CHR_PERCENT) begin
      m = MODE_RX; ph = 1;
    end else if (b0 == CHR_GREATER) begin
      if (b1 == CHR_EQUALS) begin m = MODE_GE; ph = 2; end
      else begin m = MODE_GT; ph = 1; end
    end else if (b0 == CHR_LESS) begin
      if (b1 == CHR_EQUALS) begin m = MODE_LE; ph = 2; end
      else if (b1 == CHR_GREATER) begin m = MODE_NE; ph = 2; end
      else begin m = MODE_LT; ph = 1; end
    end else if (b0 == CHR_EQUALS) begin
      if (b1 == CHR_EQUALS) begin m = MODE_EQ; ph = 2; end
      else if (b1 == CHR_GREATER) begin m = MODE_LE; ph = 2; end
      else if (b1 == CHR_LESS) begin m = MODE_GE; ph = 2; end
      else begin m = MODE_EQ; ph = 1; end
    end else if (b0 == CHR_BANG) begin
      m = MODE_NE; ph = (b1 == CHR_EQUALS) ? 2 : 1;
    end else if (b0 == CHR_BACKSLASH) begin
      m = MODE_EQ; ph = 1;
    end
    cmp_mode = m;
    if (m != MODE_RX && raw_byte(ph) == CHR_CARET) begin
      fold_en  = 1'b1;
      body_idx = ph + 1;
    end else begin
      fold_en  = 1'b0;
      body_idx = ph;
    end
  endfunction

  function automatic void restart_subject();
    live       = '0;
    live[0]    = 1'b1;
    ord_so_far = ORD_EQUAL;
    subj_pos   = 0;
  endfunction

  // An active star also activates the position after it; ascending order chains runs
  function automatic void star_closure();
    int unsigned n;
    n = body_length();
    for (int unsigned i = 0; i < n; i++) begin
      if (live[i] && body_byte(i) == CHR_STAR) live[i+1] = 1'b1;
    end
  endfunction

  function automatic void feed_char(logic [7:0] raw);
    logic [7:0]       c;
    logic [7:0]       pc;
    logic [NFA_W-1:0] nxt;
    int unsigned      n;
    c = upcase(raw);
    n = body_length();
    star_closure();
    nxt = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (live[i]) begin
        pc = body_byte(i);
        if (pc == CHR_STAR) nxt[i] = 1'b1;
        else if (pc == CHR_QUESTION || pc == c) nxt[i+1] = 1'b1;
      end
    end
    live = nxt;
    star_closure();
    // lexicographic order is settled by the first differing byte
    if (ord_so_far == ORD_EQUAL) begin
      if (subj_pos < n) begin
        pc = body_byte(subj_pos);
        if (c < pc) ord_so_far = ORD_LESS;
        else if (c > pc) ord_so_far = ORD_GREATER;
      end else begin
        ord_so_far = ORD_GREATER;
      end
    end
    if (subj_pos < PATTERN_DEPTH + 1) subj_pos++;
  endfunction

  function automatic void close_subject();
    int unsigned n;
    order_e      ord;
    out_item_t   v;
    n = body_length();
    star_closure();
    ord = ord_so_far;
    // subject ran out first: a proper prefix is the smaller string
    if (ord == ORD_EQUAL && subj_pos < n) ord = ORD_LESS;
    v.match  = 1'b0;
    v.status = STATUS_OK;
    if (ovf) begin
      v.status = STATUS_OVERFLOW;
    end else if (cmp_mode == MODE_RX) begin
      v.status = STATUS_REGEX;
    end else begin
      case (cmp_mode)
        MODE_EQ: v.match = live[n];
        MODE_NE: v.match = !live[n];
        MODE_LT: v.match = (ord == ORD_LESS);
        MODE_GT: v.match = (ord == ORD_GREATER);
        MODE_LE: v.match = (ord != ORD_GREATER);
        default: v.match = (ord != ORD_LESS);
      endcase
    end
    verdicts.push_back(v);
    restart_subject();
  endfunction

  function automatic void predict_item(in_item_t it);
    case (it.func)
      FUNC_CLEAR: begin
        pat_len = 0;
        ovf     = 1'b0;
        decode_prefix();
        restart_subject();
      end
      FUNC_APPEND: begin
        // a full store drops the byte and flags the overflow
        if (pat_len < PATTERN_DEPTH) begin
          pat_mem[pat_len] = it.data_byte;
          pat_len++;
        end else begin
          ovf = 1'b1;
        end
        decode_prefix();
        restart_subject();
      end
      FUNC_SUBJECT: feed_char(it.data_byte);
      default:      close_subject();
    endcase
  endfunction

  function automatic void check_verdict(out_item_t got);
    out_item_t want;
    if (verdicts.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("[%0t] result match=%0b status=%0d with nothing pending",
                 $realtime, got.match, got.status);
    end else begin
      want = verdicts.pop_front();
      checked_o++;
      if (got.match !== want.match || got.status !== want.status) begin
        fail_count_o++;
        if (fail_count_o <= 10)
          $display("[%0t] result %0d: expected match=%0b status=%0d, got match=%0b status=%0d",
                   $realtime, checked_o, want.match, want.status, got.match, got.status);
      end
    end
  endfunction

  // Output first: anything on it was caused by an earlier input transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len  = 0;
      ovf      = 1'b0;
      cmp_mode = MODE_EQ;
      fold_en  = 1'b0;
      body_idx = 0;
      restart_subject();
      verdicts.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_verdict(out_data_i);
      if (in_valid_i && !in_stall_i) predict_item(in_data_i);
    end
    pending_o = verdicts.size();
  end

endmodule

FILE: verif/testbench.sv
// Top of the wildcard pattern compare testbench: clock, reset, stimulus, receiver
// stalls, watchdog and verdict. Depends on wpc_pkg, wpc_match_checker and the core.
`timescale 1ns / 1ps

module testbench;
  import wpc_pkg::*;

  localparam int ITEM_TARGET    = 1700;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 16;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  wire       in_stall;
  wire       out_valid;
  out_item_t out_data;

  int fail_count;
  int pending;
  int checked;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  int items_sent    = 0;
  int quiet_cycles  = 0;

  string prefix_table [14] = '{"", "%", ">=", ">", "<=", "<>", "<", "==", "=>", "=<",
                               "=", "!=", "!", "\\"};

  wildcard_pattern_compare_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  wpc_match_checker u_match_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // One input transaction; entered and left just after a falling edge
  task automatic send_item(func_e f, logic [7:0] b);
    in_item_t it;
    it.func      = f;
    it.data_byte = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Pattern bytes biased towards a small alphabet so that globs hit often
  function automatic logic [7:0] rand_pattern_char();
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'(CHR_LOWER_A + $urandom_range(3));
      4:          return 8'(8'h41 + $urandom_range(3));
      5:          return CHR_STAR;
      6:          return CHR_QUESTION;
      7:          return 8'($urandom_range(255));
      8: begin
        case ($urandom_range(5))
          0:       return CHR_GREATER;
          1:       return CHR_LESS;
          2:       return CHR_EQUALS;
          3:       return CHR_BANG;
          4:       return CHR_PERCENT;
          default: return CHR_BACKSLASH;
        endcase
      end
      default:    return CHR_CARET;
    endcase
  endfunction

  // A pattern load followed by subjects mostly derived from its body
  task automatic run_sequence();
    string       pre;
    logic [7:0]  body [$];
    logic [7:0]  subj [$];
    logic [7:0]  b;
    int unsigned kind;
    int unsigned blen;
    int unsigned nsub;
    kind = $urandom_range(99);
    // noise: arbitrary function codes and bytes
    if (kind < 8) begin
      repeat ($urandom_range(1, 6))
        send_item(func_e'($urandom_range(3)), 8'($urandom_range(255)));
      return;
    end
    // occasionally leave the old pattern in place and extend it
    if ($urandom_range(99) < 85) send_item(FUNC_CLEAR, 8'($urandom_range(255)));
    pre = prefix_table[$urandom_range(13)];
    for (int i = 0; i < pre.len(); i++) send_item(FUNC_APPEND, pre[i]);
    if ($urandom_range(99) < 30) send_item(FUNC_APPEND, CHR_CARET);
    // a few patterns run up to and past the store depth
    if (kind < 13) begin
      blen = $urandom_range(60, 68);
      nsub = 1;
    end else begin
      blen = $urandom_range(0, 8);
      nsub = $urandom_range(1, 4);
    end
    repeat (blen) body.push_back(rand_pattern_char());
    foreach (body[i]) send_item(FUNC_APPEND, body[i]);
    repeat (nsub) begin
      subj.delete();
      foreach (body[i]) begin
        b = body[i];
        if (b == CHR_STAR) begin
          repeat ($urandom_range(0, 3)) subj.push_back(8'(CHR_LOWER_A + $urandom_range(3)));
        end else if (b == CHR_QUESTION) begin
          subj.push_back(8'($urandom_range(255)));
        end else if (((b >= 8'h41 && b <= 8'h5A) || (b >= CHR_LOWER_A && b <= CHR_LOWER_Z))
                     && $urandom_range(99) < 40) begin
          subj.push_back(b ^ CASE_OFFSET);
        end else begin
          subj.push_back(b);
        end
      end
      // perturb: shorten, lengthen, corrupt one byte, or run long
      case ($urandom_range(9))
        0: repeat ($urandom_range(1, 3)) if (subj.size() > 0) void'(subj.pop_back());
        1: subj.push_back(rand_pattern_char());
        2: if (subj.size() > 0) subj[$urandom_range(subj.size() - 1)] = 8'($urandom_range(255));
        3: repeat (8) subj.push_back(rand_pattern_char());
        default: ;
      endcase
      foreach (subj[i]) send_item(FUNC_SUBJECT, subj[i]);
      // broken streams: the pattern grows mid-subject, or the end is never sent
      if ($urandom_range(99) < 4) send_item(FUNC_APPEND, rand_pattern_char());
      if ($urandom_range(99) < 95) send_item(FUNC_END, 8'($urandom_range(255)));
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 quiet_cycles, pending);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty pattern against empty subject: equal mode, match
    send_item(FUNC_END, 8'hFF);
    // zero byte is an ordinary subject byte
    send_item(FUNC_SUBJECT, 8'h00);
    send_item(FUNC_END, 8'h00);
    // backslash forces equal, caret folds case: body becomes "A?"
    send_item(FUNC_CLEAR, 8'hFF);
    send_item(FUNC_APPEND, CHR_BACKSLASH);
    send_item(FUNC_APPEND, CHR_CARET);
    send_item(FUNC_APPEND, CHR_LOWER_A);
    send_item(FUNC_APPEND, CHR_QUESTION);
    // question mark with no subject byte left must fail
    send_item(FUNC_SUBJECT, 8'h41);
    send_item(FUNC_END, 8'h00);
    // folded subject, top-bit byte against the question mark
    send_item(FUNC_SUBJECT, CHR_LOWER_A);
    send_item(FUNC_SUBJECT, 8'hFF);
    send_item(FUNC_END, 8'h00);
    // percent selects the unsupported regex mode
    send_item(FUNC_CLEAR, 8'h00);
    send_item(FUNC_APPEND, CHR_PERCENT);
    send_item(FUNC_END, 8'h00);
    // star and a zero byte are literals in an ordering mode
    send_item(FUNC_CLEAR, 8'h00);
    send_item(FUNC_APPEND, CHR_LESS);
    send_item(FUNC_APPEND, CHR_STAR);
    send_item(FUNC_APPEND, 8'h00);
    send_item(FUNC_SUBJECT, 8'h2B);
    send_item(FUNC_END, 8'h00);

    send_idle_pct = 28;
    recv_idle_pct = 73;
    while (items_sent < ITEM_TARGET / 3) run_sequence();
    send_idle_pct = 73;
    recv_idle_pct = 28;
    while (items_sent < 2 * ITEM_TARGET / 3) run_sequence();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    while (items_sent < ITEM_TARGET) run_sequence();
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d input transactions over three stall mixes and one long output hold-off;",
             items_sent);
    $display("compared %0d end-of-subject results, %0d failures.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
